/* src/crmft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crmft_pkg
// Shared types and codes of the CAN receive id/mask filter table.
// ----------------------------------------------------------------------------
package crmft_pkg;

  localparam int IdW     = 29;
  localparam int StdIdW  = 11;
  localparam int LenW    = 4;
  localparam int StatW   = 3;
  localparam int IdxOutW = 4;
  localparam logic [LenW-1:0] MaxLen = 4'd8;

  // operation codes
  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // result status codes
  localparam logic [StatW-1:0] STAT_REGISTERED = 3'd0;
  localparam logic [StatW-1:0] STAT_INVALID    = 3'd1;
  localparam logic [StatW-1:0] STAT_OVERLAP    = 3'd2;
  localparam logic [StatW-1:0] STAT_FULL       = 3'd3;
  localparam logic [StatW-1:0] STAT_MATCHED    = 3'd4;
  localparam logic [StatW-1:0] STAT_NOMATCH    = 3'd5;
  localparam logic [StatW-1:0] STAT_DROPPED    = 3'd6;

  typedef struct packed {
    logic            op;
    logic [1:0]      bus;
    logic            extended;
    logic [IdW-1:0]  ident;
    logic [IdW-1:0]  id_mask;
    logic            fd_format;
    logic            remote;
    logic [LenW-1:0] length_code;
  } in_item_t;

  typedef struct packed {
    logic [StatW-1:0]   status;
    logic [IdxOutW-1:0] entry_index;
    logic [IdW-1:0]     frame_ident;
    logic [LenW-1:0]    frame_length;
  } out_item_t;

  // flags that travel down the cell row with the lookup token
  typedef struct packed {
    logic overlap;
    logic hit;
    logic free;
  } cell_flags_t;

  // entry write broadcast to the row
  typedef struct packed {
    logic           en;
    logic [1:0]     bus;
    logic           extended;
    logic [IdW-1:0] masked_id;
    logic [IdW-1:0] id_mask;
  } entry_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } ctrl_state_t;

endpackage
`default_nettype wire

/* src/crmft_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crmft_in_if
// Valid/ready channel carrying one filter request transaction.
// ----------------------------------------------------------------------------
interface crmft_in_if import crmft_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/crmft_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crmft_out_if
// Valid/ready channel carrying one filter result transaction.
// ----------------------------------------------------------------------------
interface crmft_out_if import crmft_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/crmft_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crmft_cell
// One filter entry; compares the held query and passes the token onwards.
// ----------------------------------------------------------------------------
module crmft_cell import crmft_pkg::*; #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_item_t    query,
  input  wire entry_wr_t   wr,
  input  wire logic [IW-1:0] wr_idx,
  input  wire logic        tok_in,
  input  wire cell_flags_t flags_in,
  input  wire logic [IW-1:0] hit_idx_in,
  input  wire logic [IW-1:0] free_idx_in,
  output logic             tok_out,
  output cell_flags_t      flags_out,
  output logic [IW-1:0]    hit_idx_out,
  output logic [IW-1:0]    free_idx_out,
  output logic             used
);

  logic           used_r;
  logic [1:0]     bus_r;
  logic           ext_r;
  logic [IdW-1:0] mid_r;
  logic [IdW-1:0] mask_r;

  logic           tok_r;
  cell_flags_t    flags_r, flags_nxt;
  logic [IW-1:0]  hit_idx_r, hit_idx_nxt;
  logic [IW-1:0]  free_idx_r, free_idx_nxt;

  logic same, overlap, match, wr_here;

  assign wr_here = wr.en && (wr_idx == IW'(IDX));
  assign same    = used_r && (bus_r == query.bus) && (ext_r == query.extended);
  assign overlap = same && (((mid_r ^ query.ident) & mask_r & query.id_mask) == '0);
  assign match   = same && (mid_r == (query.ident & mask_r));

  always_comb begin
    flags_nxt.overlap = flags_in.overlap | overlap;
    flags_nxt.hit     = flags_in.hit | match;
    flags_nxt.free    = flags_in.free | ~used_r;
    hit_idx_nxt       = flags_in.hit ? hit_idx_in : IW'(IDX);
    free_idx_nxt      = flags_in.free ? free_idx_in : IW'(IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (wr_here) begin
        used_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    flags_r    <= flags_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    if (wr_here) begin
      bus_r  <= wr.bus;
      ext_r  <= wr.extended;
      mid_r  <= wr.masked_id;
      mask_r <= wr.id_mask;
    end
  end

  assign tok_out      = tok_r;
  assign flags_out    = flags_r;
  assign hit_idx_out  = hit_idx_r;
  assign free_idx_out = free_idx_r;
  assign used         = used_r;

endmodule
`default_nettype wire

/* src/can_rx_mask_filter_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_rx_mask_filter_table_core
// CAN receive acceptance filter table with id/mask entries.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request transaction: op 0 registers a filter entry,
//   op 1 classifies a received frame. out_ch returns exactly one result
//   transaction per request (status, entry index, echoed id and length).
//   Requests that fail the range checks (bad bus, id or mask too wide,
//   FD, remote or over-length frames) are answered without a lookup:
//   the result is valid in the cycle after acceptance.
//   Other requests send a token down the row of ENTRIES cells, one cell a
//   cycle, and the result is registered as the token leaves the last cell.
//   A new request is taken only once the last result has been taken; the
//   length of the cell row sets the rate.
//   A registration writes the lowest free entry as the token leaves the row.
//   One request is in flight at a time: in_ch.ready is high only while no
//   request is pending and no result waits. A stalled out_ch holds the
//   result and keeps in_ch blocked.
//   Reset clears every entry's used bit; the table is empty afterwards.
// ----------------------------------------------------------------------------
module can_rx_mask_filter_table_core import crmft_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int BUSES   = 3
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  crmft_in_if.sink    in_ch,
  crmft_out_if.source out_ch
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  ctrl_state_t state_r, state_nxt;
  in_item_t    query_r, query_nxt;
  out_item_t   out_r, out_nxt;
  logic        start_r, start_nxt;

  logic        in_acc;
  logic        bus_bad, id_ok, mask_ok, reject;
  logic [StatW-1:0] reject_stat;

  logic [ENTRIES-1:0] tok_v;
  logic [ENTRIES-1:0] used_v;
  cell_flags_t        flg    [ENTRIES];
  logic [IW-1:0]      hidx   [ENTRIES];
  logic [IW-1:0]      fidx   [ENTRIES];

  logic          tail_v;
  cell_flags_t   tail_f;
  logic [IW-1:0] tail_hidx, tail_fidx;
  entry_wr_t     wr;
  logic [IW-1:0] wr_idx;

  assign in_acc = in_ch.valid && in_ch.ready;

  // range checks on the incoming transaction
  always_comb begin
    bus_bad = {30'd0, in_ch.data.bus} >= 32'(BUSES);
    id_ok   = in_ch.data.extended || (in_ch.data.ident[IdW-1:StdIdW] == '0);
    mask_ok = in_ch.data.extended || (in_ch.data.id_mask[IdW-1:StdIdW] == '0);
    if (in_ch.data.op == OP_REGISTER) begin
      reject      = bus_bad || !id_ok || !mask_ok;
      reject_stat = STAT_INVALID;
    end else begin
      reject      = bus_bad || in_ch.data.fd_format || in_ch.data.remote ||
                    (in_ch.data.length_code > MaxLen) || !id_ok;
      reject_stat = STAT_DROPPED;
    end
  end

  // cell row
  assign tail_v    = tok_v[ENTRIES-1];
  assign tail_f    = flg[ENTRIES-1];
  assign tail_hidx = hidx[ENTRIES-1];
  assign tail_fidx = fidx[ENTRIES-1];

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      logic          c_tok;
      cell_flags_t   c_flg;
      logic [IW-1:0] c_hidx, c_fidx;
      if (gi == 0) begin : g_head
        assign c_tok  = start_r;
        assign c_flg  = '0;
        assign c_hidx = '0;
        assign c_fidx = '0;
      end else begin : g_link
        assign c_tok  = tok_v[gi-1];
        assign c_flg  = flg[gi-1];
        assign c_hidx = hidx[gi-1];
        assign c_fidx = fidx[gi-1];
      end
      crmft_cell #(
        .IW  (IW),
        .IDX (gi)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .query        (query_r),
        .wr           (wr),
        .wr_idx       (wr_idx),
        .tok_in       (c_tok),
        .flags_in     (c_flg),
        .hit_idx_in   (c_hidx),
        .free_idx_in  (c_fidx),
        .tok_out      (tok_v[gi]),
        .flags_out    (flg[gi]),
        .hit_idx_out  (hidx[gi]),
        .free_idx_out (fidx[gi]),
        .used         (used_v[gi])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = reject ? S_HOLD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail_v) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs, result and table write
  always_comb begin
    in_ch.ready  = (state_r == S_IDLE);
    out_ch.valid = (state_r == S_HOLD);
    query_nxt    = in_acc ? in_ch.data : query_r;
    start_nxt    = in_acc && !reject;
    out_nxt      = out_r;
    wr.en        = 1'b0;
    wr.bus       = query_r.bus;
    wr.extended  = query_r.extended;
    wr.masked_id = query_r.ident & query_r.id_mask;
    wr.id_mask   = query_r.id_mask;
    wr_idx       = tail_fidx;
    case (state_r)
      S_IDLE: begin
        if (in_acc && reject) begin
          out_nxt        = '0;
          out_nxt.status = reject_stat;
        end
      end
      S_SCAN: begin
        if (tail_v) begin
          out_nxt = '0;
          if (query_r.op == OP_REGISTER) begin
            if (tail_f.overlap) begin
              out_nxt.status = STAT_OVERLAP;
            end else if (tail_f.free) begin
              out_nxt.status      = STAT_REGISTERED;
              out_nxt.entry_index = IdxOutW'(tail_fidx);
              wr.en               = 1'b1;
            end else begin
              out_nxt.status = STAT_FULL;
            end
          end else begin
            if (tail_f.hit) begin
              out_nxt.status       = STAT_MATCHED;
              out_nxt.entry_index  = IdxOutW'(tail_hidx);
              out_nxt.frame_ident  = query_r.ident;
              out_nxt.frame_length = query_r.length_code;
            end else begin
              out_nxt.status = STAT_NOMATCH;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    query_r <= query_nxt;
    out_r   <= out_nxt;
  end

  assign out_ch.data = out_r;

`ifndef NO_ASSERTIONS
  // only one lookup token may be in the cell row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_v, start_r}))
    else $error("more than one lookup token in the cell row");

  // a new transaction is taken only with the row empty
  a_ready_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (tok_v == '0) && !start_r)
    else $error("input ready while a lookup is in flight");

  // a registration never overwrites a used entry
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !used_v[wr_idx])
    else $error("entry write hits a used entry");

  // a result appears only after a lookup ends or a request is rejected
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(tail_v) || $past(in_acc))
    else $error("result without a cause");
`endif

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the CAN id/mask filter table against a behavioural copy of the table
// kept here: each request transaction is predicted when it is accepted, and
// each result transaction is compared field by field with the oldest
// prediction. Directed registration and frame checks come first, then
// back-pressure, mostly well-formed random traffic, and a full table.
// ----------------------------------------------------------------------------
module testbench;
  import crmft_pkg::*;

  localparam int ENTRIES = 16;
  localparam int BUSES   = 3;
  localparam logic [IdW-1:0] STD_ID_MAX = 29'h7FF;
  localparam logic [IdW-1:0] EXT_ID_MAX = 29'h1FFF_FFFF;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_LIMIT  = 20000;

  logic clk;
  logic rst_n;

  crmft_in_if  in_ch ();
  crmft_out_if out_ch ();

  can_rx_mask_filter_table_core #(
    .ENTRIES (ENTRIES),
    .BUSES   (BUSES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the filter table
  logic           tbl_used      [ENTRIES];
  logic [IdW-1:0] tbl_masked_id [ENTRIES];
  logic [IdW-1:0] tbl_mask      [ENTRIES];
  logic           tbl_extended  [ENTRIES];
  logic [1:0]     tbl_bus       [ENTRIES];

  out_item_t pending_results[$];
  int        mismatch_count;
  bit        steady_flow;
  int        sink_hold_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic out_item_t filter_outcome(in_item_t req);
    out_item_t      res;
    int             free_idx;
    logic [IdW-1:0] limit;
    res      = '0;
    free_idx = -1;
    limit    = req.extended ? EXT_ID_MAX : STD_ID_MAX;
    if (req.op == OP_REGISTER) begin
      if (req.bus >= BUSES || req.ident > limit || req.id_mask > limit) begin
        res.status = STAT_INVALID;
        return res;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_used[i]) begin
          if (tbl_bus[i] == req.bus && tbl_extended[i] == req.extended &&
              ((tbl_masked_id[i] ^ req.ident) & tbl_mask[i] & req.id_mask) == '0) begin
            res.status = STAT_OVERLAP;
            return res;
          end
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (free_idx < 0) begin
        res.status = STAT_FULL;
        return res;
      end
      tbl_used[free_idx]      = 1'b1;
      tbl_masked_id[free_idx] = req.ident & req.id_mask;
      tbl_mask[free_idx]      = req.id_mask;
      tbl_extended[free_idx]  = req.extended;
      tbl_bus[free_idx]       = req.bus;
      res.status      = STAT_REGISTERED;
      res.entry_index = free_idx[IdxOutW-1:0];
      return res;
    end
    if (req.bus >= BUSES || req.fd_format || req.remote || req.length_code > MaxLen ||
        req.ident > limit) begin
      res.status = STAT_DROPPED;
      return res;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_used[i] && tbl_bus[i] == req.bus && tbl_extended[i] == req.extended &&
          tbl_masked_id[i] == (req.ident & tbl_mask[i])) begin
        res.status       = STAT_MATCHED;
        res.entry_index  = i[IdxOutW-1:0];
        res.frame_ident  = req.ident;
        res.frame_length = req.length_code;
        return res;
      end
    end
    res.status = STAT_NOMATCH;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t make_req(logic op, logic [1:0] bus, logic ext,
                                        logic [IdW-1:0] ident, logic [IdW-1:0] id_mask,
                                        logic fd, logic rtr, logic [LenW-1:0] len);
    in_item_t req;
    req.op          = op;
    req.bus         = bus;
    req.extended    = ext;
    req.ident       = ident;
    req.id_mask     = id_mask;
    req.fd_format   = fd;
    req.remote      = rtr;
    req.length_code = len;
    return req;
  endfunction

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send_request(in_item_t req);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(filter_outcome(req));
    @(negedge clk);
  endtask

  function automatic in_item_t random_request();
    in_item_t       req;
    int             pick;
    int             k;
    logic [IdW-1:0] limit;
    logic [IdW-1:0] noise;
    pick  = $urandom_range(0, 99);
    noise = IdW'($urandom);
    req   = make_req(OP_CLASSIFY, 2'($urandom_range(0, BUSES - 1)),
                     1'($urandom_range(0, 1)), '0, noise, 1'b0, 1'b0,
                     LenW'($urandom_range(0, MaxLen)));
    limit = req.extended ? EXT_ID_MAX : STD_ID_MAX;
    if (pick < 12) begin
      req.op  = OP_REGISTER;
      req.bus = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, BUSES - 1));
      req.ident = IdW'($urandom) & limit;
      case ($urandom_range(0, 3))
        0: req.id_mask = IdW'($urandom) & limit;
        1: req.id_mask = IdW'($urandom & $urandom & $urandom) & limit;
        2: req.id_mask = limit;
        default: req.id_mask = (limit << $urandom_range(0, 28)) & limit;
      endcase
      // over-wide standard id or mask
      if (!req.extended && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) req.ident = IdW'($urandom);
        else req.id_mask = IdW'($urandom);
      end
      req.fd_format   = 1'($urandom_range(0, 1));
      req.remote      = 1'($urandom_range(0, 1));
      req.length_code = LenW'($urandom_range(0, 15));
      return req;
    end
    if (pick < 70) begin
      // aim at a live entry, starting the search at a random index
      k = $urandom_range(0, ENTRIES - 1);
      for (int n = 0; n < ENTRIES && !tbl_used[k]; n++) k = (k + 1) % ENTRIES;
      if (tbl_used[k]) begin
        req.bus      = tbl_bus[k];
        req.extended = tbl_extended[k];
        limit        = req.extended ? EXT_ID_MAX : STD_ID_MAX;
        req.ident    = (tbl_masked_id[k] | (IdW'($urandom) & ~tbl_mask[k])) & limit;
        // near miss on one kept bit
        if ($urandom_range(0, 4) == 0)
          req.ident = req.ident ^ (tbl_mask[k] & (IdW'(1) << $urandom_range(0, 28)));
        return req;
      end
    end
    if (pick < 85) begin
      req.ident = IdW'($urandom) & limit;
      return req;
    end
    // mostly malformed frames
    req.bus         = 2'($urandom_range(0, 3));
    req.ident       = IdW'($urandom);
    req.fd_format   = 1'($urandom_range(0, 1));
    req.remote      = 1'($urandom_range(0, 1));
    req.length_code = LenW'($urandom_range(0, 15));
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int        stall;
    out_item_t got;
    out_item_t want;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 5);
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d index %0d", got.status,
               got.entry_index);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatch_count++;
        end
        if (got.entry_index !== want.entry_index) begin
          $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
          mismatch_count++;
        end
        if (got.frame_ident !== want.frame_ident) begin
          $error("frame_ident: expected 0x%08h, got 0x%08h", want.frame_ident,
                 got.frame_ident);
          mismatch_count++;
        end
        if (got.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length,
                 got.frame_length);
          mismatch_count++;
        end
      end
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_register_rules();
    send_request(make_req(OP_REGISTER, 2'd0, 1'b0, 29'h123, 29'h7FF, 1'b0, 1'b0, 4'd0));
    // same range again, narrower mask
    send_request(make_req(OP_REGISTER, 2'd0, 1'b0, 29'h123, 29'h7F0, 1'b0, 1'b0, 4'd0));
    // standard id and mask one bit too wide
    send_request(make_req(OP_REGISTER, 2'd0, 1'b0, 29'h800, 29'h7FF, 1'b0, 1'b0, 4'd0));
    send_request(make_req(OP_REGISTER, 2'd0, 1'b0, 29'h001, 29'hFFF, 1'b0, 1'b0, 4'd0));
    send_request(make_req(OP_REGISTER, 2'd3, 1'b0, 29'h010, 29'h7FF, 1'b1, 1'b1, 4'd15));
    send_request(make_req(OP_REGISTER, 2'd1, 1'b1, EXT_ID_MAX, EXT_ID_MAX, 1'b0, 1'b0,
                          4'd0));
    send_request(make_req(OP_REGISTER, 2'd1, 1'b1, 29'h0, EXT_ID_MAX, 1'b0, 1'b0, 4'd0));
    // catch-all entry, stored id collapses to zero
    send_request(make_req(OP_REGISTER, 2'd2, 1'b1, 29'h0AB_CDEF, 29'h0, 1'b0, 1'b0, 4'd0));
    // same id as entry 0 but extended type
    send_request(make_req(OP_REGISTER, 2'd0, 1'b1, 29'h123, 29'h7FF, 1'b0, 1'b0, 4'd0));
    send_request(make_req(OP_REGISTER, 2'd0, 1'b0, 29'h7FF, 29'h700, 1'b0, 1'b0, 4'd0));
  endtask

  task automatic test_frame_classification();
    send_request(make_req(OP_CLASSIFY, 2'd0, 1'b0, 29'h123, EXT_ID_MAX, 1'b0, 1'b0, 4'd8));
    send_request(make_req(OP_CLASSIFY, 2'd0, 1'b0, 29'h7AB, 29'h0, 1'b0, 1'b0, 4'd0));
    send_request(make_req(OP_CLASSIFY, 2'd0, 1'b0, 29'h124, 29'h0, 1'b0, 1'b0, 4'd3));
    send_request(make_req(OP_CLASSIFY, 2'd0, 1'b0, 29'h123, 29'h0, 1'b1, 1'b0, 4'd8));
    send_request(make_req(OP_CLASSIFY, 2'd0, 1'b0, 29'h123, 29'h0, 1'b0, 1'b1, 4'd8));
    send_request(make_req(OP_CLASSIFY, 2'd0, 1'b0, 29'h123, 29'h0, 1'b0, 1'b0, 4'd9));
    send_request(make_req(OP_CLASSIFY, 2'd0, 1'b0, 29'h123, 29'h0, 1'b0, 1'b0, 4'd15));
    send_request(make_req(OP_CLASSIFY, 2'd3, 1'b0, 29'h123, 29'h0, 1'b0, 1'b0, 4'd1));
    // standard frame id past 11 bits
    send_request(make_req(OP_CLASSIFY, 2'd0, 1'b0, 29'h800, 29'h0, 1'b0, 1'b0, 4'd1));
    send_request(make_req(OP_CLASSIFY, 2'd2, 1'b1, 29'h155_5555, 29'h0, 1'b0, 1'b0, 4'd5));
    send_request(make_req(OP_CLASSIFY, 2'd1, 1'b1, EXT_ID_MAX, 29'h0, 1'b0, 1'b0, 4'd8));
    send_request(make_req(OP_CLASSIFY, 2'd1, 1'b0, 29'h0, 29'h0, 1'b0, 1'b0, 4'd2));
  endtask

  // receiver stalls for a long stretch while requests keep coming
  task automatic test_input_backpressure();
    steady_flow      = 1'b1;
    sink_hold_cycles = 200;
    repeat (12) send_request(random_request());
    steady_flow = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      send_request(random_request());
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_full_table();
    int       guard;
    bit       has_free;
    in_item_t req;
    guard    = 0;
    has_free = 1'b1;
    while (has_free && guard < 200) begin
      send_request(make_req(OP_REGISTER, 2'($urandom_range(0, BUSES - 1)), 1'b1,
                            IdW'($urandom), EXT_ID_MAX, 1'b0, 1'b0, 4'd0));
      has_free = 1'b0;
      for (int i = 0; i < ENTRIES; i++) if (!tbl_used[i]) has_free = 1'b1;
      guard++;
    end
    // overlap takes precedence over full
    req = make_req(OP_REGISTER, tbl_bus[0], tbl_extended[0], tbl_masked_id[0], tbl_mask[0],
                   1'b0, 1'b0, 4'd0);
    send_request(req);
    send_request(make_req(OP_REGISTER, 2'($urandom_range(0, BUSES - 1)), 1'b1,
                          IdW'($urandom), EXT_ID_MAX, 1'b0, 1'b0, 4'd0));
    send_request(make_req(OP_CLASSIFY, tbl_bus[ENTRIES-1], tbl_extended[ENTRIES-1],
                          tbl_masked_id[ENTRIES-1], 29'h0, 1'b0, 1'b0, 4'd4));
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data       = '0;
    mismatch_count   = 0;
    steady_flow      = 1'b0;
    sink_hold_cycles = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_used[i]      = 1'b0;
      tbl_masked_id[i] = '0;
      tbl_mask[i]      = '0;
      tbl_extended[i]  = 1'b0;
      tbl_bus[i]       = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_rules();
    test_frame_classification();
    test_input_backpressure();
    test_random_traffic();
    test_full_table();

    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // catch any stray transaction after the last one
    repeat (ENTRIES + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* can_rx_mask_filter_table_core.f */
src/crmft_pkg.sv
src/crmft_in_if.sv
src/crmft_out_if.sv
src/crmft_cell.sv
src/can_rx_mask_filter_table_core.sv
sim/testbench.sv
